@@ sv/sss_pkg.sv @@
package sss_pkg;

   // default buffer sizes and fixed field widths
   localparam int PATTERN_MAX_DEF = 64;
   localparam int TEXT_MAX_DEF    = 4096;
   localparam int ALPHABET_SIZE   = 256;
   localparam int BYTE_W          = 8;
   localparam int INDEX_W         = 12;

   // controller to datapath
   typedef struct packed {
      logic accept;     // request taken this cycle
      logic rd_cmp;     // read text[pos+k] and pattern[k]
      logic k_inc;      // next byte of the window
      logic rd_next;    // read the text byte after the window
      logic rd_tbl;     // look up the shift for that byte
      logic advance;    // move the window on
      logic load_rsp;   // capture the result payload
      logic rsp_found;  // found flag for the result
   } sss_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pat_empty;      // pattern length is zero
      logic window_fits;    // pos + m <= n
      logic window_at_end;  // pos + m >= n
      logic bytes_equal;    // compared bytes agree
      logic k_last;         // compared the last pattern byte
   } sss_sts_type;

endpackage

@@ sv/sss_ctrl.sv @@
module sss_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_type,
   input  logic                 req_last,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  sss_pkg::sss_sts_type sts,
   output sss_pkg::sss_cmd_type cmd
);
   import sss_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_START  = 3'd1;
   localparam logic [2:0] S_RD     = 3'd2;
   localparam logic [2:0] S_CMP    = 3'd3;
   localparam logic [2:0] S_RDNX   = 3'd4;
   localparam logic [2:0] S_TBL    = 3'd5;
   localparam logic [2:0] S_ADV    = 3'd6;
   localparam logic [2:0] S_FINISH = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       found_ff, found_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // input is taken only between searches
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // search sequencer
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      cmd.accept   = req_valid && (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.accept && req_type && req_last) begin
               state_in = S_START;
            end
         end
         S_START: begin
            if (sts.pat_empty) begin
               found_in = 1'b1;
               state_in = S_FINISH;
            end else if (!sts.window_fits) begin
               found_in = 1'b0;
               state_in = S_FINISH;
            end else begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            cmd.rd_cmp = 1'b1;
            state_in   = S_CMP;
         end
         S_CMP: begin
            if (sts.bytes_equal) begin
               if (sts.k_last) begin
                  found_in = 1'b1;
                  state_in = S_FINISH;
               end else begin
                  cmd.k_inc = 1'b1;
                  state_in  = S_RD;
               end
            end else if (sts.window_at_end) begin
               found_in = 1'b0;
               state_in = S_FINISH;
            end else begin
               state_in = S_RDNX;
            end
         end
         S_RDNX: begin
            cmd.rd_next = 1'b1;
            state_in    = S_TBL;
         end
         S_TBL: begin
            cmd.rd_tbl = 1'b1;
            state_in   = S_ADV;
         end
         S_ADV: begin
            cmd.advance = 1'b1;
            state_in    = S_START;
         end
         S_FINISH: begin
            // wait for the output slot to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp  = 1'b1;
               cmd.rsp_found = found_ff;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ sv/sss_dp.sv @@
module sss_dp #(
   parameter int PATTERN_MAX = sss_pkg::PATTERN_MAX_DEF,
   parameter int TEXT_MAX    = sss_pkg::TEXT_MAX_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_type,
   input  logic [sss_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic                         req_last,
   input  sss_pkg::sss_cmd_type         cmd,
   output sss_pkg::sss_sts_type         sts,
   output logic                         rsp_found,
   output logic [sss_pkg::INDEX_W-1:0]  rsp_match_index,
   output logic                         rsp_truncated
);
   import sss_pkg::*;

   localparam int PL_W  = $clog2(PATTERN_MAX + 1);
   localparam int PA_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int TL_W  = $clog2(TEXT_MAX + 1);
   localparam int TA_W  = $clog2(TEXT_MAX);
   localparam int SUM_W = $clog2(TEXT_MAX + PATTERN_MAX + 2);

   // buffers; the shift table holds last position + 1 of each byte
   logic [BYTE_W-1:0] pat_mem  [PATTERN_MAX];
   logic [BYTE_W-1:0] text_mem [TEXT_MAX];
   logic [PL_W-1:0]   tbl_mem  [ALPHABET_SIZE];

   logic [PL_W-1:0]          pat_len_ff, pat_len_in;
   logic [TL_W-1:0]          txt_len_ff, txt_len_in;
   logic                     closed_ff, closed_in;
   logic                     ovf_seen_ff, ovf_seen_in;
   logic                     pat_ovf_ff, pat_ovf_in;
   logic [ALPHABET_SIZE-1:0] seen_ff, seen_in;

   logic [TL_W-1:0]   srch_len_ff, srch_len_in;
   logic              trunc_ff, trunc_in;
   logic [TL_W-1:0]   pos_ff, pos_in;
   logic [PA_W-1:0]   k_ff, k_in;
   logic [BYTE_W-1:0] text_rd_ff, pat_rd_ff;
   logic [PL_W-1:0]   tbl_rd_ff;
   logic              tbl_hit_ff;
   logic                found_ff;
   logic [INDEX_W-1:0]  index_ff;
   logic                trunc_out_ff;

   logic [PL_W-1:0]  p_len_cur;
   logic             p_room, t_room, pat_wr, txt_wr;
   logic [SUM_W-1:0] win_end, rd_sum, pos_next;
   logic [TA_W-1:0]  text_addr;
   logic [PL_W-1:0]  shift_sub;

   // request bookkeeping: lengths, drop flags, pattern open/closed
   always_comb begin
      p_len_cur   = closed_ff ? '0 : pat_len_ff;
      p_room      = (p_len_cur != PL_W'(PATTERN_MAX));
      t_room      = (txt_len_ff != TL_W'(TEXT_MAX));
      pat_wr      = cmd.accept && !req_type && p_room;
      txt_wr      = cmd.accept && req_type && t_room;
      pat_len_in  = pat_len_ff;
      txt_len_in  = txt_len_ff;
      closed_in   = closed_ff;
      ovf_seen_in = ovf_seen_ff;
      pat_ovf_in  = pat_ovf_ff;
      seen_in     = seen_ff;
      srch_len_in = srch_len_ff;
      trunc_in    = trunc_ff;
      if (cmd.accept && !req_type) begin
         // a pattern byte after a closed pattern starts afresh
         pat_len_in  = p_len_cur + PL_W'(p_room);
         pat_ovf_in  = (!closed_ff && pat_ovf_ff) || !p_room;
         ovf_seen_in = (!closed_ff && ovf_seen_ff) || !p_room;
         txt_len_in  = closed_ff ? '0 : txt_len_ff;
         seen_in     = closed_ff ? '0 : seen_ff;
         if (p_room) begin
            seen_in[req_data_byte] = 1'b1;
         end
         closed_in = req_last;
      end else if (cmd.accept) begin
         closed_in = 1'b1;
         if (req_last) begin
            srch_len_in = txt_len_ff + TL_W'(t_room);
            trunc_in    = ovf_seen_ff || !t_room;
            txt_len_in  = '0;
            ovf_seen_in = pat_ovf_ff;
         end else begin
            txt_len_in  = txt_len_ff + TL_W'(t_room);
            ovf_seen_in = ovf_seen_ff || !t_room;
         end
      end
   end

   // window position and byte counter
   always_comb begin
      win_end   = SUM_W'(pos_ff) + SUM_W'(pat_len_ff);
      rd_sum    = cmd.rd_next ? win_end : (SUM_W'(pos_ff) + SUM_W'(k_ff));
      text_addr = rd_sum[TA_W-1:0];
      shift_sub = tbl_hit_ff ? tbl_rd_ff : '0;
      pos_next  = win_end - SUM_W'(shift_sub) + SUM_W'(1);
      pos_in    = pos_ff;
      k_in      = k_ff;
      if (cmd.accept && req_type && req_last) begin
         pos_in = '0;
         k_in   = '0;
      end else if (cmd.k_inc) begin
         k_in = k_ff + PA_W'(1);
      end else if (cmd.advance) begin
         pos_in = pos_next[TL_W-1:0];
         k_in   = '0;
      end
   end

   // status back to the controller
   always_comb begin
      sts.pat_empty     = (pat_len_ff == '0);
      sts.window_fits   = (win_end <= SUM_W'(srch_len_ff));
      sts.window_at_end = (win_end >= SUM_W'(srch_len_ff));
      sts.bytes_equal   = (text_rd_ff == pat_rd_ff);
      sts.k_last        = ((PL_W'(k_ff) + PL_W'(1)) == pat_len_ff);
   end

   // buffer writes and registered reads
   always_ff @(posedge clock) begin
      if (pat_wr) begin
         pat_mem[p_len_cur[PA_W-1:0]] <= req_data_byte;
         tbl_mem[req_data_byte]       <= p_len_cur + PL_W'(1);
      end
      if (txt_wr) begin
         text_mem[txt_len_ff[TA_W-1:0]] <= req_data_byte;
      end
      if (cmd.rd_cmp || cmd.rd_next) begin
         text_rd_ff <= text_mem[text_addr];
      end
      if (cmd.rd_cmp) begin
         pat_rd_ff <= pat_mem[k_ff];
      end
      if (cmd.rd_tbl) begin
         tbl_rd_ff <= tbl_mem[text_rd_ff];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff  <= '0;
         txt_len_ff  <= '0;
         closed_ff   <= 1'b1;
         ovf_seen_ff <= 1'b0;
         pat_ovf_ff  <= 1'b0;
         seen_ff     <= '0;
      end else begin
         pat_len_ff  <= pat_len_in;
         txt_len_ff  <= txt_len_in;
         closed_ff   <= closed_in;
         ovf_seen_ff <= ovf_seen_in;
         pat_ovf_ff  <= pat_ovf_in;
         seen_ff     <= seen_in;
      end
   end

   // search registers and result payload
   always_ff @(posedge clock) begin
      srch_len_ff <= srch_len_in;
      trunc_ff    <= trunc_in;
      pos_ff      <= pos_in;
      k_ff        <= k_in;
      if (cmd.rd_tbl) begin
         tbl_hit_ff <= seen_ff[text_rd_ff];
      end
      if (cmd.load_rsp) begin
         found_ff     <= cmd.rsp_found;
         index_ff     <= cmd.rsp_found ? INDEX_W'(pos_ff) : '0;
         trunc_out_ff <= trunc_ff;
      end
   end

   assign rsp_found       = found_ff;
   assign rsp_match_index = index_ff;
   assign rsp_truncated   = trunc_out_ff;

endmodule

@@ sv/sunday_substring_search_unit.sv @@
// Channel | Ports                                              | Direction
// req     | req_valid req_stall req_type req_data_byte req_last | in
// rsp     | rsp_valid rsp_stall rsp_found rsp_match_index       | out
//         | rsp_truncated                                      |
//
// Pattern and text bytes load one per cycle while req_stall is low. A last text
// byte starts the search, during which req_stall is high: a window start step,
// a read then a compare per byte (on the single text read port), next-byte
// read, shift table read and add per skip, plus a step to load the result.
// Reset clears lengths and flags at once; no clearing pass over the buffers.
// Bytes keep loading while a finished result waits on rsp_stall.
module sunday_substring_search_unit #(
   parameter int PATTERN_MAX = sss_pkg::PATTERN_MAX_DEF,
   parameter int TEXT_MAX    = sss_pkg::TEXT_MAX_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_type,
   input  logic [sss_pkg::BYTE_W-1:0]  req_data_byte,
   input  logic                        req_last,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_found,
   output logic [sss_pkg::INDEX_W-1:0] rsp_match_index,
   output logic                        rsp_truncated
);
   import sss_pkg::*;

   sss_cmd_type cmd;
   sss_sts_type sts;

   sss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_last  (req_last),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   sss_dp #(
      .PATTERN_MAX (PATTERN_MAX),
      .TEXT_MAX    (TEXT_MAX)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_type        (req_type),
      .req_data_byte   (req_data_byte),
      .req_last        (req_last),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_found       (rsp_found),
      .rsp_match_index (rsp_match_index),
      .rsp_truncated   (rsp_truncated)
   );

endmodule

@@ sv/sss_chk.sv @@
module sss_chk (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        req_type,
   input logic                        req_last,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_found,
   input logic [sss_pkg::INDEX_W-1:0] rsp_match_index,
   input logic                        rsp_truncated
);

   logic req_take;
   assign req_take = req_valid && !req_stall;

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found)
         && $stable(rsp_match_index) && $stable(rsp_truncated))
      else $error("result changed while stalled");

   // a miss reports index zero
   a_miss_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_match_index == '0)
      else $error("miss with non-zero index");

   // the last text byte starts a search that holds off requests
   a_search_stall: assert property (@(posedge clock) disable iff (reset)
      req_take && req_type && req_last |=> req_stall)
      else $error("no stall after last text byte");

   // any other request leaves the input open
   a_load_open: assert property (@(posedge clock) disable iff (reset)
      req_take && !(req_type && req_last) |=> !req_stall)
      else $error("stall after a loading request");

   // nothing comes out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("activity right after reset");

endmodule

bind sunday_substring_search_unit sss_chk u_sss_chk (.*);
